### rtl/elsp_pkg.sv
`default_nettype none
package elsp_pkg;

  typedef struct packed {
    logic [31:0] seg_type;
    logic [31:0] seg_flags;
    logic [63:0] seg_file_offset;
    logic [63:0] seg_vaddr;
    logic [63:0] seg_file_size;
    logic [63:0] seg_mem_size;
    logic [63:0] seg_alignment;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        segment_recorded;
    logic [3:0]  segment_index;
    logic [63:0] mapping_alignment;
    logic [63:0] mapping_start;
    logic [63:0] mapping_file_offset;
    logic [63:0] mapping_length;
    logic [63:0] load_base;
    logic [63:0] load_length;
    logic [63:0] header_table_vaddr;
    logic        header_table_known;
    logic        interp_present;
  } out_t;

  typedef enum logic [2:0] {
    REG_PAGE_BYTES    = 3'd0,
    REG_TABLE_OFFSET  = 3'd1,
    REG_ENTRY_SIZE    = 3'd2,
    REG_ENTRY_COUNT   = 3'd3,
    REG_WINDOW_LENGTH = 3'd4,
    REG_IMAGE_TYPE    = 3'd5
  } reg_idx_e;

  localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [1:0] STATUS_DONE     = 2'd1;
  localparam logic [1:0] STATUS_ERROR    = 2'd2;

  localparam logic [31:0] SEG_LOAD   = 32'd1;
  localparam logic [31:0] SEG_INTERP = 32'd3;
  localparam logic [31:0] SEG_PHDR   = 32'd6;
  localparam logic [31:0] SEG_STACK  = 32'h6474_e551;

  localparam logic [15:0] ET_EXEC = 16'd2;
  localparam logic [15:0] ET_DYN  = 16'd3;

  localparam logic [15:0] ENTRY_MIN = 16'd56;
  localparam logic [31:0] HDR_MIN   = 32'd64;

  localparam logic [63:0] PAGE_BYTES_RST   = 64'd4096;
  localparam logic [63:0] TABLE_OFFSET_RST = 64'd64;
  localparam logic [15:0] ENTRY_SIZE_RST   = 16'd56;
  localparam logic [15:0] ENTRY_COUNT_RST  = 16'd0;
  localparam logic [31:0] WINDOW_LEN_RST   = 32'd0;
  localparam logic [15:0] IMAGE_TYPE_RST   = 16'd2;

endpackage
`default_nettype wire

### rtl/elf_load_segment_planner_core.sv
`default_nettype none
// An accepted entry beat goes into the input register, then through one pass of 64-bit
// add/compare/mask logic into the result register.
// Throughput: one entry per cycle; the output register takes a new result whenever the
// previous one is taken, so the input stalls only while the result register is held.
// Reset: configuration returns to page 4096, table offset 64, entry size 56, type 2, the
// rest zero; run state clears at reset and again after the last entry of each image.
module elf_load_segment_planner_core #(
  parameter int MAX_SEGMENTS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire elsp_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output elsp_pkg::out_t     out_data_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [5:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import elsp_pkg::*;

  localparam int SegW = $clog2(MAX_SEGMENTS + 1);

  function automatic logic is_pow2(input logic [63:0] v);
    is_pow2 = (v != 64'd0) && ((v & (v - 64'd1)) == 64'd0);
  endfunction

  // configuration
  logic [63:0] page_bytes_q, table_offset_q;
  logic [15:0] entry_size_q, entry_count_q, image_type_q;
  logic [31:0] window_length_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_bytes_q    <= PAGE_BYTES_RST;
      table_offset_q  <= TABLE_OFFSET_RST;
      entry_size_q    <= ENTRY_SIZE_RST;
      entry_count_q   <= ENTRY_COUNT_RST;
      window_length_q <= WINDOW_LEN_RST;
      image_type_q    <= IMAGE_TYPE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PAGE_BYTES:    page_bytes_q    <= pwdata;
        REG_TABLE_OFFSET:  table_offset_q  <= pwdata;
        REG_ENTRY_SIZE:    entry_size_q    <= pwdata[15:0];
        REG_ENTRY_COUNT:   entry_count_q   <= pwdata[15:0];
        REG_WINDOW_LENGTH: window_length_q <= pwdata[31:0];
        REG_IMAGE_TYPE:    image_type_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PAGE_BYTES:    prdata = page_bytes_q;
      REG_TABLE_OFFSET:  prdata = table_offset_q;
      REG_ENTRY_SIZE:    prdata = {48'd0, entry_size_q};
      REG_ENTRY_COUNT:   prdata = {48'd0, entry_count_q};
      REG_WINDOW_LENGTH: prdata = {32'd0, window_length_q};
      REG_IMAGE_TYPE:    prdata = {48'd0, image_type_q};
      default:           prdata = 64'd0;
    endcase
  end

  // handshake
  logic s1_valid_q, out_valid_q, advance, fire;
  in_t  s1_q;
  out_t out_q, out_d;

  assign advance     = !out_valid_q || out_ready_i;
  assign fire        = s1_valid_q && advance;
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (advance)    out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) s1_q <= in_data_i;
    if (fire) out_q <= out_d;
  end

  // run state
  logic [15:0]   pos_q, pos_d;
  logic [SegW-1:0] seg_cnt_q, seg_cnt_d;
  logic [63:0]   lowest_q, lowest_d, highest_q, highest_d, tbl_vaddr_q, tbl_vaddr_d;
  logic          tbl_valid_q, tbl_valid_d, interp_q, interp_d, failed_q, failed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      seg_cnt_q   <= '0;
      lowest_q    <= '0;
      highest_q   <= '0;
      tbl_vaddr_q <= '0;
      tbl_valid_q <= 1'b0;
      interp_q    <= 1'b0;
      failed_q    <= 1'b0;
    end else if (fire) begin
      pos_q       <= pos_d;
      seg_cnt_q   <= seg_cnt_d;
      lowest_q    <= lowest_d;
      highest_q   <= highest_d;
      tbl_vaddr_q <= tbl_vaddr_d;
      tbl_valid_q <= tbl_valid_d;
      interp_q    <= interp_d;
      failed_q    <= failed_d;
    end
  end

  // entry evaluation
  logic        excess, last, hdr_bad, entry_ok, ok, rec, final_bad;
  logic [16:0] pos_inc;
  logic [31:0] start_rel, tsize;
  logic [64:0] start_sum, end_sum, foff_sum, vend_sum, round_sum;
  logic        end_past_win, sz_bad, off_ovf;
  logic        is_load, is_interp, is_table, req_big, load_bad, infer;
  logic [63:0] al, al_m1, mstart, mend, toff_rel, fsz_rem, mlen;
  logic [SegW+3:0] seg_ext;

  assign pos_inc = {1'b0, pos_q} + 17'd1;
  assign excess  = (entry_count_q == 16'd0) || (pos_q >= entry_count_q);
  assign last    = excess || (pos_inc == {1'b0, entry_count_q});

  assign hdr_bad = (pos_q == 16'd0) &&
                   (!is_pow2(page_bytes_q) ||
                    (image_type_q != ET_EXEC && image_type_q != ET_DYN) ||
                    entry_size_q < ENTRY_MIN || window_length_q < HDR_MIN ||
                    table_offset_q >= {32'd0, window_length_q});

  assign start_rel    = {16'd0, pos_q} * {16'd0, entry_size_q};
  assign start_sum    = {1'b0, table_offset_q} + {33'd0, start_rel};
  assign end_sum      = {1'b0, start_sum[63:0]} + {49'd0, ENTRY_MIN};
  assign end_past_win = (end_sum[63:32] != 32'd0) || (end_sum[31:0] > window_length_q);
  assign sz_bad       = (s1_q.seg_mem_size != 64'd0) &&
                        (s1_q.seg_file_size > s1_q.seg_mem_size);
  assign foff_sum     = {1'b0, s1_q.seg_file_offset} + {1'b0, s1_q.seg_file_size};
  assign off_ovf      = foff_sum[64];

  assign entry_ok = !hdr_bad && !start_sum[64] && !end_sum[64] && !end_past_win &&
                    !sz_bad && !off_ovf;

  assign is_load   = (s1_q.seg_type == SEG_LOAD) && (s1_q.seg_mem_size != 64'd0);
  assign is_interp = (s1_q.seg_type == SEG_INTERP);
  assign is_table  = (s1_q.seg_type == SEG_PHDR);

  // mapping record
  assign req_big   = s1_q.seg_alignment > 64'd1;
  assign al        = (req_big && s1_q.seg_alignment > page_bytes_q) ?
                     s1_q.seg_alignment : page_bytes_q;
  assign al_m1     = al - 64'd1;
  assign mstart    = s1_q.seg_vaddr & ~al_m1;
  assign vend_sum  = {1'b0, s1_q.seg_vaddr} + {1'b0, s1_q.seg_mem_size};
  assign round_sum = {1'b0, vend_sum[63:0]} + {1'b0, al_m1};
  assign mend      = round_sum[63:0] & ~al_m1;
  assign mlen      = mend - mstart;

  assign load_bad = (seg_cnt_q >= SegW'(MAX_SEGMENTS)) || !is_pow2(page_bytes_q) ||
                    (req_big && !is_pow2(s1_q.seg_alignment)) ||
                    vend_sum[64] || round_sum[64] || (mend < mstart);

  assign ok  = !failed_q && !excess && entry_ok && !(is_load && load_bad);
  assign rec = ok && is_load;

  // header table covered by this segment's file image
  assign tsize    = {16'd0, entry_size_q} * {16'd0, entry_count_q};
  assign toff_rel = table_offset_q - s1_q.seg_file_offset;
  assign fsz_rem  = s1_q.seg_file_size - {32'd0, tsize};
  assign infer    = !tbl_valid_q && (tsize != 32'd0) &&
                    (s1_q.seg_file_size >= {32'd0, tsize}) &&
                    (table_offset_q >= s1_q.seg_file_offset) && (toff_rel <= fsz_rem);

  assign seg_ext = {4'd0, seg_cnt_q};

  always_comb begin
    seg_cnt_d   = seg_cnt_q + SegW'(rec);
    lowest_d    = lowest_q;
    highest_d   = highest_q;
    tbl_vaddr_d = tbl_vaddr_q;
    tbl_valid_d = tbl_valid_q;
    interp_d    = interp_q || (ok && is_interp);
    if (rec) begin
      if (seg_cnt_q == '0 || mstart < lowest_q) lowest_d = mstart;
      if (seg_cnt_q == '0 || mend > highest_q) highest_d = mend;
      if (infer) begin
        tbl_vaddr_d = s1_q.seg_vaddr + toff_rel;
        tbl_valid_d = 1'b1;
      end
    end
    if (ok && is_table) begin
      tbl_vaddr_d = s1_q.seg_vaddr;
      tbl_valid_d = 1'b1;
    end

    final_bad = !ok || (last && (seg_cnt_d == '0 || highest_d < lowest_d));

    out_d = '0;
    if (final_bad) begin
      out_d.status = STATUS_ERROR;
    end else begin
      out_d.status             = last ? STATUS_DONE : STATUS_ACCEPTED;
      out_d.segment_recorded   = rec;
      if (rec) begin
        out_d.segment_index       = seg_ext[3:0];
        out_d.mapping_alignment   = al;
        out_d.mapping_start       = mstart;
        out_d.mapping_file_offset = s1_q.seg_file_offset & ~al_m1;
        out_d.mapping_length      = mlen;
      end
      out_d.load_base          = lowest_d;
      out_d.load_length        = last ? (highest_d - lowest_d) : 64'd0;
      out_d.header_table_vaddr = tbl_valid_d ? tbl_vaddr_d : 64'd0;
      out_d.header_table_known = tbl_valid_d;
      out_d.interp_present     = interp_d;
    end

    failed_d = final_bad;
    pos_d    = pos_inc[15:0];
    // last entry (or an excess one) closes the run
    if (last) begin
      pos_d       = '0;
      seg_cnt_d   = '0;
      lowest_d    = '0;
      highest_d   = '0;
      tbl_vaddr_d = '0;
      tbl_valid_d = 1'b0;
      interp_d    = 1'b0;
      failed_d    = 1'b0;
    end
  end

endmodule
`default_nettype wire
